// File: sv/cvcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the console velocity command parser.
// No dependencies; imported by the interfaces, the top level and the testbench.

package cvcp_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int VEL_W  = 32;
	localparam int STEP_W = 16;
	localparam int DIG_W  = 4;
	localparam int ACC_W  = 31;

	// Character codes
	localparam logic [BYTE_W-1:0] KEY_ESC     = 8'd27;
	localparam logic [BYTE_W-1:0] KEY_BRACKET = 8'd91;
	localparam logic [BYTE_W-1:0] KEY_DEL     = 8'd127;
	localparam logic [BYTE_W-1:0] KEY_BS      = 8'd8;
	localparam logic [BYTE_W-1:0] KEY_CR      = 8'd13;
	localparam logic [BYTE_W-1:0] KEY_LF      = 8'd10;
	localparam logic [BYTE_W-1:0] KEY_0       = 8'd48;
	localparam logic [BYTE_W-1:0] KEY_9       = 8'd57;
	localparam logic [BYTE_W-1:0] KEY_UP      = 8'd65;
	localparam logic [BYTE_W-1:0] KEY_DOWN    = 8'd66;
	localparam logic [BYTE_W-1:0] KEY_RIGHT   = 8'd67;
	localparam logic [BYTE_W-1:0] KEY_LEFT    = 8'd68;

	// Saturation limits
	localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// Register reset values
	localparam logic [STEP_W-1:0] COARSE_RESET = 16'd100;
	localparam logic [STEP_W-1:0] FINE_RESET   = 16'd5;

	// Update source codes
	localparam logic SRC_ARROW = 1'b0;
	localparam logic SRC_TYPED = 1'b1;

	typedef enum logic [0:0] {
		CFG_COARSE = 1'b0,
		CFG_FINE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} cvcp_state_t;

endpackage

`default_nettype wire

// File: sv/cvcp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Handshake channels of the parser: byte input, result output and register writes.
// Depends on cvcp_pkg.

interface cvcp_byte_if import cvcp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cvcp_result_if import cvcp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VEL_W-1:0] velocity;
	logic             update_source;

	modport source (output valid, output velocity, output update_source, input ready);
	modport sink   (input valid, input velocity, input update_source, output ready);
endinterface

interface cvcp_cfg_if import cvcp_pkg::*; ();
	logic              valid;
	logic              ready;
	cfg_reg_t          index;
	logic [STEP_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/cvcp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module cvcp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 15,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/console_velocity_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the console velocity command parser.
// Depends on cvcp_pkg, the interfaces in cvcp_if.sv and cvcp_ram.
//
//  port  | dir | word carried                          | accepted when
//  ------+-----+---------------------------------------+-------------------------
//  rx    | in  | rx_byte, one console character        | rx.valid & rx.ready
//  res   | out | velocity, update_source               | res.valid & res.ready
//  cfg   | in  | index (coarse/fine step), data        | cfg.valid & cfg.ready
//
// Sequencing: a completed arrow sequence passes through the EMIT state to the
// output register. Enter with buffered digits passes through CONV and then EMIT:
// the digit RAM has one read port, so the decimal conversion consumes one digit a
// cycle.
// Reset clears the target, escape and digit counts and loads the step registers;
// the digit RAM is not cleared, since only entries below the count are ever read.
// A waiting result does not block input; only a second result waits for it.

module console_velocity_command_parser import cvcp_pkg::*; #(
	parameter int BUFFER_SIZE = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cvcp_byte_if.sink      rx,
	cvcp_result_if.source  res,
	cvcp_cfg_if.sink       cfg
);

	// Digit store holds BUFFER_SIZE-1 digits; the count must reach that value.
	localparam int DEPTH  = BUFFER_SIZE - 1;
	localparam int CNT_W  = $clog2(BUFFER_SIZE);
	localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	cvcp_state_t state_q, state_d;

	logic [VEL_W-1:0]  vel_q;
	logic              src_q;
	logic [STEP_W-1:0] coarse_q, fine_q;
	logic [1:0]        esc_cnt_q;
	logic [BYTE_W-1:0] esc_b0_q, esc_b1_q;
	logic [CNT_W-1:0]  dcnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic              rd_s1;
	logic [ACC_W-1:0]  acc_q;

	logic              res_valid_q;
	logic [VEL_W-1:0]  res_vel_q;
	logic              res_src_q;

	// Control decoded from the state and the incoming word
	logic byte_acc;
	logic esc_capture, esc_close, arrow_hit;
	logic digit_push, digit_pop;
	logic conv_start, conv_issue, conv_done;
	logic load_res;

	logic [DIG_W-1:0]  ram_rdata;

	// Arrow arithmetic
	logic              arrow_known, arrow_neg;
	logic [STEP_W-1:0] arrow_step;
	logic [VEL_W+1:0]  arrow_sum;
	logic [VEL_W+1:0]  arrow_delta;
	logic [VEL_W-1:0]  vel_arrow;

	// Decimal accumulate: acc * 10 + digit
	logic [ACC_W+3:0]  acc_ext;
	logic [ACC_W-1:0]  acc_sat;

	assign byte_acc  = rx.valid && rx.ready;
	assign rx.ready  = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign res.valid         = res_valid_q;
	assign res.velocity      = res_vel_q;
	assign res.update_source = res_src_q;

	// Next state and control
	always_comb begin
		state_d     = state_q;
		esc_capture = 1'b0;
		esc_close   = 1'b0;
		arrow_hit   = 1'b0;
		digit_push  = 1'b0;
		digit_pop   = 1'b0;
		conv_start  = 1'b0;
		conv_issue  = 1'b0;
		conv_done   = 1'b0;
		load_res    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (byte_acc) begin
					if (esc_cnt_q != 2'd0 || rx.rx_byte == KEY_ESC) begin
						// Capture every byte while a sequence is open
						if (esc_cnt_q < 2'd2) begin
							esc_capture = 1'b1;
						end else begin
							esc_close = 1'b1;
							if (esc_b0_q == KEY_ESC && esc_b1_q == KEY_BRACKET) begin
								arrow_hit = 1'b1;
								state_d   = ST_EMIT;
							end
						end
					end else if (rx.rx_byte inside {[KEY_0:KEY_9]}) begin
						// Drop digits once the buffer is full
						digit_push = (dcnt_q < DEPTH_C);
					end else if (rx.rx_byte inside {KEY_CR, KEY_LF}) begin
						if (dcnt_q != '0) begin
							conv_start = 1'b1;
							state_d    = ST_CONV;
						end
					end else if (rx.rx_byte inside {KEY_DEL, KEY_BS}) begin
						digit_pop = (dcnt_q != '0);
					end
				end
			end
			ST_CONV: begin
				conv_issue = (idx_q != dcnt_q);
				if (idx_q == dcnt_q && !rd_s1) begin
					conv_done = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || res.ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Arrow step: pick step and direction, add with 34-bit headroom, saturate
	always_comb begin
		arrow_known = 1'b1;
		arrow_neg   = 1'b0;
		arrow_step  = fine_q;
		case (rx.rx_byte)
			KEY_UP:    arrow_step = coarse_q;
			KEY_DOWN:  begin
				arrow_step = coarse_q;
				arrow_neg  = 1'b1;
			end
			KEY_RIGHT: arrow_step = fine_q;
			KEY_LEFT:  arrow_neg  = 1'b1;
			default:   arrow_known = 1'b0;
		endcase
		arrow_delta = {{(VEL_W+2-STEP_W){1'b0}}, arrow_step};
		if (arrow_neg) begin
			arrow_delta = -arrow_delta;
		end
		arrow_sum = {{2{vel_q[VEL_W-1]}}, vel_q} + arrow_delta;
		if (!arrow_known) begin
			vel_arrow = vel_q;
		end else if (arrow_sum[VEL_W+1:VEL_W-1] != 3'b000
				&& arrow_sum[VEL_W+1:VEL_W-1] != 3'b111) begin
			vel_arrow = arrow_sum[VEL_W+1] ? VEL_MIN : VEL_MAX;
		end else begin
			vel_arrow = arrow_sum[VEL_W-1:0];
		end
	end

	assign acc_ext = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{(ACC_W+4-DIG_W){1'b0}}, ram_rdata};
	assign acc_sat = (acc_ext > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_ext[ACC_W-1:0];

	// Digit store: write at the fill count, read at the conversion index
	cvcp_ram #(
		.WIDTH (DIG_W),
		.DEPTH (DEPTH)
	) u_digits (
		.clk   (clk),
		.we    (digit_push),
		.waddr (dcnt_q[RAM_AW-1:0]),
		.wdata (rx.rx_byte[DIG_W-1:0]),
		.raddr (idx_q[RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q       <= '0;
			src_q       <= SRC_ARROW;
			coarse_q    <= COARSE_RESET;
			fine_q      <= FINE_RESET;
			esc_cnt_q   <= '0;
			esc_b0_q    <= '0;
			esc_b1_q    <= '0;
			dcnt_q      <= '0;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_COARSE: coarse_q <= cfg.data;
					CFG_FINE:   fine_q   <= cfg.data;
					default:    ;
				endcase
			end

			// Escape sequence capture
			if (esc_capture) begin
				if (esc_cnt_q == 2'd0) begin
					esc_b0_q <= rx.rx_byte;
				end else begin
					esc_b1_q <= rx.rx_byte;
				end
				esc_cnt_q <= esc_cnt_q + 2'd1;
			end
			if (esc_close) begin
				esc_cnt_q <= '0;
			end
			if (arrow_hit) begin
				vel_q <= vel_arrow;
				src_q <= SRC_ARROW;
			end

			// Digit buffer fill count
			if (digit_push) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (digit_pop) begin
				dcnt_q <= dcnt_q - 1'b1;
			end

			// Conversion: issue one read a cycle, accumulate in the cycle after
			if (conv_start) begin
				idx_q <= '0;
				acc_q <= '0;
				src_q <= SRC_TYPED;
			end
			rd_s1 <= conv_issue;
			if (conv_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_s1) begin
				acc_q <= acc_sat;
			end
			if (conv_done) begin
				vel_q  <= {1'b0, acc_q};
				dcnt_q <= '0;
			end

			// Output register: load on emit, drop once taken
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_vel_q <= vel_q;
			res_src_q <= src_q;
		end
	end

endmodule

`default_nettype wire

// File: sv/cvcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the console velocity command parser and their bind.
// Depends on console_velocity_command_parser and the interfaces in cvcp_if.sv.

module cvcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rx_valid,
	input wire logic        rx_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] res_velocity,
	input wire logic        res_source
);

	// Hold a stalled result word unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_velocity) && $stable(res_source))
		else $error("result word changed while stalled");

	// A result is only loaded while input is held off
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!rx_ready))
		else $error("result loaded while input was open");

	// Input stays open until a word is taken
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		$past(rx_ready && !rx_valid) |-> rx_ready)
		else $error("input closed without an accepted word");

	// No stale result straight out of reset
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !res_valid)
		else $error("result valid after reset");

endmodule

bind console_velocity_command_parser cvcp_checker u_cvcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_velocity (res.velocity),
	.res_source   (res.update_source)
);

`default_nettype wire

// File: verif/tb_console_velocity_command_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for console_velocity_command_parser: directed and random console
// traffic, a scoreboard class that predicts every report, and register writes between phases.
// Depends on cvcp_pkg, the channel interfaces in cvcp_if.sv and the parser RTL.

module tb_console_velocity_command_parser;
	import cvcp_pkg::*;

	localparam int DIGIT_SLOTS   = 15;       // the block buffers BUFFER_SIZE-1 digits
	localparam int SETTLE_CYCLES = 24;       // covers the longest enter, with 15 digits
	localparam int DRAIN_LIMIT   = 100000;   // give up waiting on reports after this
	localparam int PHASE_WORDS   = 150;      // meaningful words per random phase

	// Predicts the velocity reports and matches them against the output channel.
	class velocity_scoreboard;
		typedef struct packed {
			logic [VEL_W-1:0] vel;
			logic             src;
		} report_t;

		report_t                 report_q[$];
		logic signed [VEL_W-1:0] target;
		logic [1:0]              esc_count;
		logic [BYTE_W-1:0]       esc_bytes [2];
		logic [DIG_W-1:0]        digits [DIGIT_SLOTS];
		int unsigned             digit_count;
		logic [STEP_W-1:0]       coarse;
		logic [STEP_W-1:0]       fine;
		int                      errors;

		function new();
			target       = '0;
			esc_count    = '0;
			esc_bytes[0] = '0;
			esc_bytes[1] = '0;
			digit_count  = 0;
			coarse       = COARSE_RESET;
			fine         = FINE_RESET;
			errors       = 0;
		endfunction

		function void set_step(input cfg_reg_t idx, input logic [STEP_W-1:0] val);
			if (idx == CFG_COARSE)
				coarse = val;
			else
				fine = val;
		endfunction

		// Saturating add of a signed step to the held target.
		function logic signed [VEL_W-1:0] nudge(input longint delta);
			longint sum;
			sum = longint'(target) + delta;
			if (sum > longint'($signed(VEL_MAX)))
				sum = longint'($signed(VEL_MAX));
			if (sum < longint'($signed(VEL_MIN)))
				sum = longint'($signed(VEL_MIN));
			return sum[VEL_W-1:0];
		endfunction

		function void note_byte(input logic [BYTE_W-1:0] b);
			longint      acc;
			int unsigned n;
			if (esc_count != 0 || b == KEY_ESC) begin
				// every byte of an open sequence is captured, ESC and digits included
				if (esc_count < 2) begin
					esc_bytes[esc_count] = b;
					esc_count++;
					return;
				end
				esc_count = '0;
				if (esc_bytes[0] != KEY_ESC || esc_bytes[1] != KEY_BRACKET)
					return;
				case (b)
					KEY_UP:    target = nudge(longint'(coarse));
					KEY_DOWN:  target = nudge(-longint'(coarse));
					KEY_RIGHT: target = nudge(longint'(fine));
					KEY_LEFT:  target = nudge(-longint'(fine));
					default:   ;
				endcase
				report_q.push_back('{vel: target, src: SRC_ARROW});
				return;
			end
			if (b >= KEY_0 && b <= KEY_9) begin
				if (digit_count < DIGIT_SLOTS) begin
					digits[digit_count] = DIG_W'(b - KEY_0);
					digit_count++;
				end
				return;
			end
			if (b == KEY_CR || b == KEY_LF) begin
				n = digit_count;
				digit_count = 0;
				if (n == 0)
					return;
				acc = 0;
				for (int unsigned i = 0; i < n; i++) begin
					acc = acc * 10 + longint'(digits[i]);
					if (acc > longint'($signed(VEL_MAX)))
						acc = longint'($signed(VEL_MAX));
				end
				target = acc[VEL_W-1:0];
				report_q.push_back('{vel: target, src: SRC_TYPED});
				return;
			end
			if ((b == KEY_DEL || b == KEY_BS) && digit_count > 0)
				digit_count--;
		endfunction

		function void check(input logic [VEL_W-1:0] vel, input logic src);
			report_t exp;
			if (report_q.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual velocity %0d source %0d",
					$time, $signed(vel), src);
				errors++;
				return;
			end
			exp = report_q.pop_front();
			if (vel !== exp.vel) begin
				$display("%0t: velocity mismatch, expected %0d, actual %0d",
					$time, $signed(exp.vel), $signed(vel));
				errors++;
			end
			if (src !== exp.src) begin
				$display("%0t: update_source mismatch, expected %0d, actual %0d",
					$time, exp.src, src);
				errors++;
			end
		endfunction

		function int pending();
			return report_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;

	velocity_scoreboard sb;

	cvcp_byte_if   rx_if ();
	cvcp_result_if res_if ();
	cvcp_cfg_if    cfg_if ();

	console_velocity_command_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: drop ready at random on the falling edge, per the current stall rate.
	always @(negedge clk) begin
		res_if.ready = ($urandom_range(99) >= sink_idle_pct);
	end

	// Check every report accepted on the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check(res_if.velocity, res_if.update_source);
	end

	// Hold valid with one byte until the block takes it; may idle first.
	// Entered and left on a falling edge.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid = 1'b0;
			@(negedge clk);
		end
		rx_if.valid   = 1'b1;
		rx_if.rx_byte = b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_arrow(input logic [BYTE_W-1:0] key);
		send_byte(KEY_ESC);
		send_byte(KEY_BRACKET);
		send_byte(key);
	endtask

	task automatic type_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Write one step register; only called while the parser is quiet.
	task automatic write_step(input cfg_reg_t idx, input logic [STEP_W-1:0] val);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		sb.set_step(idx, val);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Drop the byte channel, wait for every outstanding report, then let the
	// longest silent operation run out.
	task automatic settle();
		int waited;
		rx_if.valid = 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One random phrase; mostly well-formed commands with random content, some
	// broken sequences and some line noise. Noise is not counted.
	task automatic random_phrase(inout int unsigned counted);
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 38) begin
			// typed number, occasionally long enough to fill the buffer
			n = ($urandom_range(7) == 0) ? $urandom_range(11, 18) : $urandom_range(1, 10);
			for (int unsigned i = 0; i < n; i++) begin
				send_byte(BYTE_W'(KEY_0 + $urandom_range(9)));
				counted++;
				if ($urandom_range(5) == 0) begin
					send_byte($urandom_range(1) ? KEY_BS : KEY_DEL);
					counted++;
				end
				// an arrow mid-number must leave the digit buffer alone
				if ($urandom_range(11) == 0) begin
					send_arrow(BYTE_W'(KEY_UP + $urandom_range(3)));
					counted += 3;
				end
			end
			send_byte($urandom_range(1) ? KEY_CR : KEY_LF);
			counted++;
		end else if (pick < 70) begin
			if ($urandom_range(4) != 0)
				send_arrow(BYTE_W'(KEY_UP + $urandom_range(3)));
			else
				send_arrow(BYTE_W'($urandom_range(255)));
			counted += 3;
		end else if (pick < 82) begin
			// sequence with random tail, usually not ESC '['
			send_byte(KEY_ESC);
			send_byte(BYTE_W'($urandom_range(255)));
			send_byte(BYTE_W'($urandom_range(255)));
			counted += 3;
		end else if (pick < 90) begin
			case ($urandom_range(3))
				0: send_byte(KEY_BS);
				1: send_byte(KEY_DEL);
				2: send_byte(KEY_CR);
				default: send_byte(KEY_LF);
			endcase
			counted++;
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) send_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	task automatic random_phase();
		int unsigned counted;
		counted = 0;
		while (counted < PHASE_WORDS)
			random_phrase(counted);
	endtask

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		sb              = new();
		src_idle_pct    = 9;
		sink_idle_pct   = 55;
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.rx_byte   = '0;
		res_if.ready    = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.index    = CFG_COARSE;
		cfg_if.data     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: arrows at the reset steps, up/right/down/left back to zero
		send_arrow(KEY_UP);
		send_arrow(KEY_RIGHT);
		send_arrow(KEY_DOWN);
		send_arrow(KEY_LEFT);
		// unknown final byte ('Z') still reports the held target
		send_arrow(8'h5A);
		// ESC 'x' 'A' is not ESC '[' and is dropped silently
		send_byte(KEY_ESC);
		send_byte(8'h78);
		send_byte(KEY_UP);
		// ESC is captured like any byte while a sequence is open
		send_byte(KEY_ESC);
		send_byte(KEY_ESC);
		send_byte(KEY_BRACKET);
		// digits and enter inside a sequence are captured, not parsed
		send_byte(KEY_ESC);
		send_byte(BYTE_W'(KEY_0 + 5));
		send_byte(KEY_LF);
		// edits on an empty buffer, then ignored bytes at both ends of the range
		send_byte(KEY_BS);
		send_byte(KEY_DEL);
		send_byte(KEY_CR);
		send_byte(KEY_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		// typed number with backspace
		type_string("12");
		send_byte(KEY_DEL);
		type_string("0");
		send_byte(KEY_LF);
		// one past the largest value saturates
		type_string("2147483648");
		send_byte(KEY_CR);
		// 18 nines: the buffer keeps 15, the value saturates
		type_string("999999999999999999");
		send_byte(KEY_CR);

		// Largest coarse step pushes against the upper limit; zero fine step holds
		settle();
		write_step(CFG_COARSE, 16'hFFFF);
		write_step(CFG_FINE, 16'h0000);
		send_arrow(KEY_UP);
		send_arrow(KEY_RIGHT);
		send_arrow(KEY_LEFT);

		// Random, sender mostly busy, receiver stalling often
		settle();
		write_step(CFG_COARSE, STEP_W'($urandom_range(65535)));
		write_step(CFG_FINE, STEP_W'($urandom_range(1000)));
		random_phase();

		// Random, roles swapped; zero coarse step, largest fine step
		settle();
		src_idle_pct  = 55;
		sink_idle_pct = 9;
		write_step(CFG_COARSE, 16'h0000);
		write_step(CFG_FINE, 16'hFFFF);
		random_phase();

		// Random, no idling on either side
		settle();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		write_step(CFG_COARSE, STEP_W'($urandom_range(1, 1000)));
		write_step(CFG_FINE, STEP_W'($urandom_range(65535)));
		random_phase();

		// Step below zero with the largest steps
		settle();
		write_step(CFG_COARSE, 16'hFFFF);
		write_step(CFG_FINE, 16'hFFFF);
		type_string("0");
		send_byte(KEY_CR);
		send_arrow(KEY_DOWN);
		send_arrow(KEY_DOWN);
		send_arrow(KEY_LEFT);
		send_arrow(KEY_UP);

		settle();
		if (sb.pending() != 0)
			$display("%0t: %0d reports never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
sv/cvcp_pkg.sv
sv/cvcp_if.sv
sv/cvcp_ram.sv
sv/console_velocity_command_parser.sv
sv/cvcp_checker.sv
verif/tb_console_velocity_command_parser.sv
